// ----- rtl/slpg_pkg.sv -----
package slpg_pkg;

   localparam int SampleWidth = 24;
   localparam int GainWidth   = 25;
   localparam int CeilWidth   = 23;
   localparam int CoeffWidth  = 24;
   localparam int FracBits    = 24;
   localparam int DivSteps    = 24;
   localparam int CountWidth  = $clog2(DivSteps + 1);

   localparam logic [GainWidth-1:0]   UnityGain    = 25'h1000000;
   localparam logic [CeilWidth-1:0]   CeilingReset = 23'd4194304;
   localparam logic [CoeffWidth-1:0]  CoeffReset   = 24'd16775468;
   localparam logic [SampleWidth-1:0] PeakLimit    = 24'd8388608;

   localparam logic CsrCeiling = 1'b0;
   localparam logic CsrRelease = 1'b1;

   typedef struct packed {
      logic signed [SampleWidth-1:0] sample_left;
      logic signed [SampleWidth-1:0] sample_right;
      logic                          block_end;
   } req_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] limited_left;
      logic signed [SampleWidth-1:0] limited_right;
      logic [GainWidth-1:0]          gain_now;
      logic [SampleWidth-1:0]        block_peak;
   } rsp_type;

   typedef struct packed {
      logic                   start;
      logic [CeilWidth-1:0]   ceiling;
      logic [SampleWidth-1:0] divisor;
   } div_req_type;

endpackage

// ----- rtl/slpg_lane.sv -----
module slpg_lane
   import slpg_pkg::*;
(
   input  logic                          clock,
   input  logic signed [SampleWidth-1:0] sample,
   input  logic [GainWidth-1:0]          gain,
   input  logic                          scale_en,
   output logic [SampleWidth-1:0]        magnitude,
   output logic [SampleWidth-1:0]        scaled_mag,
   output logic signed [SampleWidth-1:0] limited
);

   logic [SampleWidth-1:0]             sample_bits;
   logic [SampleWidth+GainWidth-2:0]   product;
   logic [SampleWidth-1:0]             scaled_ff;
   logic [SampleWidth-1:0]             scaled_in;

   assign sample_bits = sample;
   assign magnitude   = sample_bits[SampleWidth-1] ? (~sample_bits + 1'b1) : sample_bits;

   // magnitude <= 2^23 and gain <= 2^24, so the product fits in 48 bits
   assign product   = (SampleWidth+GainWidth-1)'(magnitude) * (SampleWidth+GainWidth-1)'(gain);
   assign scaled_in = product[FracBits +: SampleWidth];

   always_ff @(posedge clock) begin
      if (scale_en) begin
         scaled_ff <= scaled_in;
      end
   end

   assign scaled_mag = scaled_ff;
   assign limited    = (sample_bits[SampleWidth-1] && scaled_ff != '0) ?
                       (~scaled_ff + 1'b1) : scaled_ff;

endmodule

// ----- rtl/slpg_merge.sv -----
module slpg_merge
   import slpg_pkg::*;
(
   input  logic [SampleWidth-1:0] mag_left,
   input  logic [SampleWidth-1:0] mag_right,
   input  logic [SampleWidth-1:0] scaled_left,
   input  logic [SampleWidth-1:0] scaled_right,
   input  logic [SampleWidth-1:0] tracker,
   output logic [SampleWidth-1:0] peak,
   output logic [SampleWidth-1:0] block_peak
);

   logic [SampleWidth-1:0] scaled_max;

   assign peak       = (mag_left > mag_right) ? mag_left : mag_right;
   assign scaled_max = (scaled_left > scaled_right) ? scaled_left : scaled_right;
   assign block_peak = (scaled_max > tracker) ? scaled_max : tracker;

endmodule

// ----- rtl/slpg_divider.sv -----
module slpg_divider
   import slpg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  div_req_type            div_req,
   output logic                   busy,
   output logic [SampleWidth-1:0] quotient
);

   logic [CountWidth-1:0]  count_ff;
   logic [SampleWidth-1:0] rem_ff;
   logic [SampleWidth-1:0] quot_ff;
   logic [SampleWidth-1:0] divisor_ff;
   logic [SampleWidth:0]   trial;
   logic [SampleWidth:0]   diff;
   logic                   fits;
   logic [SampleWidth-1:0] rem_in;

   // quotient is known to stay below 2^24, so the remainder starts at the ceiling
   assign trial  = {rem_ff, 1'b0};
   assign diff   = trial - {1'b0, divisor_ff};
   assign fits   = trial >= {1'b0, divisor_ff};
   assign rem_in = fits ? diff[SampleWidth-1:0] : trial[SampleWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (div_req.start) begin
         count_ff <= CountWidth'(DivSteps);
      end else if (count_ff != '0) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff     <= SampleWidth'(div_req.ceiling);
         divisor_ff <= div_req.divisor;
         quot_ff    <= '0;
      end else if (count_ff != '0) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[SampleWidth-2:0], fits};
      end
   end

   assign busy     = count_ff != '0;
   assign quotient = quot_ff;

endmodule

// ----- rtl/stereo_peak_limiter_gain.sv -----
// Flow: on release a word passes the test, decide, scale and output states; when the gain
// must drop, a 24-step serial divide of ceiling by peak runs between decide and scale.
// One word is in flight at a time: a new word is accepted only in the idle state, and the
// divide on attack sets the worst case. A finished word may wait in the output
// register while the next one is accepted.
// Reset: synchronous; gain returns to unity, block peak to zero, registers to defaults.
module stereo_peak_limiter_gain
   import slpg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CoeffWidth-1:0] csr_wdata
);

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StTest   = 3'd1;
   localparam logic [2:0] StDecide = 3'd2;
   localparam logic [2:0] StDiv    = 3'd3;
   localparam logic [2:0] StScale  = 3'd4;
   localparam logic [2:0] StOut    = 3'd5;

   localparam int ProdWidth = SampleWidth + FracBits;

   logic [2:0]                   state_ff;
   logic [2:0]                   state_in;
   logic [CeilWidth-1:0]         ceiling_ff;
   logic [CoeffWidth-1:0]        coeff_ff;
   logic [GainWidth-1:0]         held_gain_ff;
   logic [SampleWidth-1:0]       tracker_ff;
   logic signed [SampleWidth-1:0] left_ff;
   logic signed [SampleWidth-1:0] right_ff;
   logic                         end_ff;
   logic [SampleWidth-1:0]       peak_ff;
   logic [ProdWidth-1:0]         attack_prod_ff;
   logic [ProdWidth-1:0]         release_prod_ff;
   logic [GainWidth-1:0]         gain_ff;
   rsp_type                      rsp_ff;
   logic                         rsp_valid_ff;

   logic [SampleWidth-1:0]       mag_left;
   logic [SampleWidth-1:0]       mag_right;
   logic [SampleWidth-1:0]       scaled_left;
   logic [SampleWidth-1:0]       scaled_right;
   logic signed [SampleWidth-1:0] lim_left;
   logic signed [SampleWidth-1:0] lim_right;
   logic [SampleWidth-1:0]       peak;
   logic [SampleWidth-1:0]       block_peak;
   logic                         attack;
   logic [GainWidth-1:0]         release_gain;
   logic [GainWidth-1:0]         release_capped;
   div_req_type                  div_req;
   logic                         div_busy;
   logic [SampleWidth-1:0]       quotient;
   logic                         req_fire;
   logic                         out_load;

   assign req_ready = state_ff == StIdle;
   assign req_fire  = req_valid && req_ready;
   assign out_load  = (state_ff == StOut) && (!rsp_valid_ff || rsp_ready);

   slpg_lane u_lane_left (
      .clock      (clock),
      .sample     (left_ff),
      .gain       (gain_ff),
      .scale_en   (state_ff == StScale),
      .magnitude  (mag_left),
      .scaled_mag (scaled_left),
      .limited    (lim_left)
   );

   slpg_lane u_lane_right (
      .clock      (clock),
      .sample     (right_ff),
      .gain       (gain_ff),
      .scale_en   (state_ff == StScale),
      .magnitude  (mag_right),
      .scaled_mag (scaled_right),
      .limited    (lim_right)
   );

   slpg_merge u_merge (
      .mag_left     (mag_left),
      .mag_right    (mag_right),
      .scaled_left  (scaled_left),
      .scaled_right (scaled_right),
      .tracker      (tracker_ff),
      .peak         (peak),
      .block_peak   (block_peak)
   );

   // start, ceiling, divisor
   assign div_req = {(state_ff == StDecide) && attack, ceiling_ff, peak_ff};

   slpg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign attack = (attack_prod_ff > {1'b0, ceiling_ff, {FracBits{1'b0}}}) && (peak_ff != '0);
   assign release_gain = GainWidth'(release_prod_ff[ProdWidth-1:FracBits]) +
                         (UnityGain - GainWidth'(coeff_ff));
   assign release_capped = (release_gain > UnityGain) ? UnityGain : release_gain;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle:   if (req_fire) state_in = StTest;
         StTest:   state_in = StDecide;
         StDecide: state_in = attack ? StDiv : StScale;
         StDiv:    if (!div_busy) state_in = StScale;
         StScale:  state_in = StOut;
         StOut:    if (out_load) state_in = StIdle;
         default:  state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         ceiling_ff   <= CeilingReset;
         coeff_ff     <= CoeffReset;
         held_gain_ff <= UnityGain;
         tracker_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CsrCeiling: ceiling_ff <= csr_wdata[CeilWidth-1:0];
               CsrRelease: coeff_ff   <= csr_wdata;
               default:    ;
            endcase
         end
         if (out_load) begin
            held_gain_ff <= gain_ff;
            tracker_ff   <= end_ff ? '0 : block_peak;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         left_ff  <= req_data.sample_left;
         right_ff <= req_data.sample_right;
         end_ff   <= req_data.block_end;
      end
      if (state_ff == StTest) begin
         peak_ff         <= peak;
         attack_prod_ff  <= ProdWidth'(peak) * ProdWidth'(held_gain_ff);
         release_prod_ff <= ProdWidth'(coeff_ff) * ProdWidth'(held_gain_ff);
      end
      if (state_ff == StDecide && !attack) begin
         gain_ff <= release_capped;
      end
      if (state_ff == StDiv && !div_busy) begin
         gain_ff <= GainWidth'(quotient);
      end
      if (out_load) begin
         rsp_ff.limited_left  <= lim_left;
         rsp_ff.limited_right <= lim_right;
         rsp_ff.gain_now      <= gain_ff;
         rsp_ff.block_peak    <= block_peak;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_held_gain_unity: assert property (@(posedge clock) disable iff (reset)
      held_gain_ff <= UnityGain)
      else $error("held gain above unity");

   a_rsp_gain_unity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.gain_now <= UnityGain)
      else $error("reported gain above unity");

   a_rsp_peak_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.block_peak <= PeakLimit)
      else $error("block peak out of range");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff && state_ff == StIdle)
      else $error("result load did not complete");

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == StDiv)
      else $error("divider running outside divide state");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import slpg_pkg::*;

   localparam int WatchdogLimit = 5000;
   localparam int PhaseWords    = 190;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic                  csr_index;
   logic [CoeffWidth-1:0] csr_wdata;

   // shadow copy of the limiter state and registers
   logic [CeilWidth-1:0]   ceiling_cfg;
   logic [CoeffWidth-1:0]  release_cfg;
   logic [GainWidth-1:0]   gain_state;
   logic [SampleWidth-1:0] meter_state;

   rsp_type limited_q[$];
   rsp_type want_word;

   int errors;
   int words_checked;
   int gain_drops;
   int block_ends;
   int csr_writes;
   int burst_left;
   bit sender_gaps;
   int stall_mode;
   int hold_left;
   int rx_count;
   int idle_cycles;

   stereo_peak_limiter_gain uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] magnitude(input logic [SampleWidth-1:0] v);
      return v[SampleWidth-1] ? 64'h1000000 - {40'd0, v} : {40'd0, v};
   endfunction

   function automatic rsp_type predict_limiter(input req_type w);
      logic [63:0] mag_l;
      logic [63:0] mag_r;
      logic [63:0] peak;
      logic [63:0] gain;
      logic [63:0] unity;
      logic [63:0] ceil_wide;
      logic [63:0] coeff;
      logic [63:0] out_l;
      logic [63:0] out_r;
      logic [63:0] meter;
      rsp_type     r;
      unity = 64'(UnityGain);
      mag_l = magnitude(w.sample_left);
      mag_r = magnitude(w.sample_right);
      peak = (mag_l > mag_r) ? mag_l : mag_r;
      gain = 64'(gain_state);
      if (gain > unity) gain = unity;
      ceil_wide = 64'(ceiling_cfg) << FracBits;
      coeff = 64'(release_cfg);
      if (peak != 0 && peak * gain > ceil_wide) begin
         gain = ceil_wide / peak;
         gain_drops++;
      end else begin
         gain = (coeff * gain + (unity - coeff) * unity) >> FracBits;
      end
      if (gain > unity) gain = unity;
      gain_state = gain[GainWidth-1:0];
      out_l = (mag_l * gain) >> FracBits;
      out_r = (mag_r * gain) >> FracBits;
      r.limited_left  = w.sample_left[SampleWidth-1]  ? -out_l[SampleWidth-1:0]
                                                      : out_l[SampleWidth-1:0];
      r.limited_right = w.sample_right[SampleWidth-1] ? -out_r[SampleWidth-1:0]
                                                      : out_r[SampleWidth-1:0];
      meter = 64'(meter_state);
      if (out_l > meter) meter = out_l;
      if (out_r > meter) meter = out_r;
      r.gain_now = gain[GainWidth-1:0];
      r.block_peak = meter[SampleWidth-1:0];
      meter_state = w.block_end ? '0 : meter[SampleWidth-1:0];
      if (w.block_end) block_ends++;
      return r;
   endfunction

   function automatic logic [SampleWidth-1:0] pick_sample(input bit loud);
      logic [SampleWidth-1:0] mag;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: mag = 24'h800000;
               1: mag = 24'h7FFFFF;
               2: mag = 24'h000000;
               3: mag = 24'h000001;
               default: mag = 24'hFFFFFF;
            endcase
            return mag;
         end
         1: return 24'($urandom());
         default: begin
            mag = loud ? 24'($urandom_range(1 << 21, 8388607))
                       : 24'($urandom_range(0, 1 << 20));
            return $urandom_range(0, 1) ? -mag : mag;
         end
      endcase
   endfunction

   // valid stays high across back-to-back words; it only drops for a gap or while draining
   task automatic send_word(input logic [SampleWidth-1:0] left,
                            input logic [SampleWidth-1:0] right, input bit last);
      req_type w;
      w.sample_left = left;
      w.sample_right = right;
      w.block_end = last;
      if (sender_gaps && burst_left <= 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      limited_q.push_back(predict_limiter(w));
      burst_left--;
   endtask

   task automatic wait_drained;
      @(negedge clock);
      req_valid <= 1'b0;
      wait (limited_q.size() == 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CoeffWidth-1:0] data);
      wait_drained();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == CsrCeiling) ceiling_cfg = data[CeilWidth-1:0];
      else release_cfg = data;
      csr_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_defaults;
      send_word(24'd0, 24'd0, 1'b0);
      send_word(24'd4194304, -24'sd4194304, 1'b0);
      send_word(24'd4194305, 24'd0, 1'b0);
      send_word(24'd8388607, 24'h800000, 1'b0);
      send_word(24'hFFFFFF, 24'd1, 1'b1);
   endtask

   task automatic test_ceiling_extremes;
      csr_write(CsrCeiling, 24'd0);
      send_word(24'd1000, -24'sd5, 1'b0);
      send_word(24'd0, 24'd0, 1'b0);
      send_word(24'h800000, 24'd8388607, 1'b1);
      // top bit lies above the register and must be dropped
      csr_write(CsrCeiling, 24'hFFFFFF);
      send_word(24'h800000, 24'd0, 1'b0);
      send_word(24'd8388607, 24'd8388607, 1'b1);
      csr_write(CsrCeiling, 24'(CeilingReset));
   endtask

   task automatic test_release_extremes;
      csr_write(CsrRelease, 24'd0);
      send_word(24'd8388607, 24'd0, 1'b0);
      send_word(24'd100, -24'sd100, 1'b0);
      send_word(24'd0, 24'd0, 1'b1);
      csr_write(CsrRelease, 24'hFFFFFF);
      send_word(24'h800000, 24'h800000, 1'b0);
      send_word(24'd5, -24'sd5, 1'b0);
      send_word(24'd0, 24'd0, 1'b1);
      csr_write(CsrRelease, CoeffReset);
   endtask

   task automatic test_block_end;
      send_word(24'd8388607, 24'd0, 1'b1);
      send_word(24'd0, 24'd0, 1'b1);
      send_word(-24'sd3000, 24'd2000, 1'b0);
      send_word(24'd10, 24'd10, 1'b1);
   endtask

   task automatic test_backpressure;
      stall_mode = 0;
      sender_gaps = 1'b0;
      hold_left = 300;
      repeat (48) send_word(pick_sample(1'b1), pick_sample(1'b0), $urandom_range(0, 7) == 0);
   endtask

   // loud bursts force gain drops, quiet stretches let the gain recover
   task automatic test_random_traffic;
      int  n;
      int  seg;
      bit  loud;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               csr_write(CsrCeiling, 24'h7FFFFF);
               csr_write(CsrRelease, 24'd0);
            end
            1: begin
               csr_write(CsrCeiling, 24'($urandom_range(0, 1 << 16)));
               csr_write(CsrRelease, 24'hFFFFFF);
            end
            2: begin
               csr_write(CsrCeiling, 24'd0);
               csr_write(CsrRelease, 24'($urandom_range(0, 24'hFFFFFF)));
            end
            default: begin
               csr_write(CsrCeiling, 24'($urandom_range(0, 24'hFFFFFF)));
               csr_write(CsrRelease,
                         24'($urandom_range(0, 1) ? $urandom_range(0, 24'hFFFFFF)
                                                  : $urandom_range(15000000, 24'hFFFFFF)));
            end
         endcase
         stall_mode = (phase == 0) ? 0 : $urandom_range(0, 3);
         sender_gaps = (phase != 0) && ($urandom_range(0, 3) != 0);
         n = 0;
         while (n < PhaseWords) begin
            loud = ($urandom_range(0, 3) == 0);
            seg = loud ? $urandom_range(1, 6) : $urandom_range(4, 30);
            repeat (seg) begin
               send_word(pick_sample(loud), pick_sample(loud), $urandom_range(0, 15) == 0);
               n++;
            end
         end
      end
   endtask

   initial begin
      rsp_ready = 1'b0;
      rx_count = 0;
      forever begin
         @(negedge clock);
         rx_count++;
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ((rx_count % 7) < 3);
               default: rsp_ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   task automatic report_field(input string field, input logic [24:0] want_v,
                               input logic [24:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want_v, got_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (limited_q.size() == 0) begin
            $display("%0t: unexpected word, expected none actual %p", $time, rsp_data);
            errors++;
         end else begin
            want_word = limited_q.pop_front();
            report_field("limited_left", 25'(want_word.limited_left),
                         25'(rsp_data.limited_left));
            report_field("limited_right", 25'(want_word.limited_right),
                         25'(rsp_data.limited_right));
            report_field("gain_now", want_word.gain_now, rsp_data.gain_now);
            report_field("block_peak", 25'(want_word.block_peak), 25'(rsp_data.block_peak));
            words_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CsrCeiling;
      csr_wdata = '0;
      ceiling_cfg = CeilingReset;
      release_cfg = CoeffReset;
      gain_state = UnityGain;
      meter_state = '0;
      errors = 0;
      words_checked = 0;
      gain_drops = 0;
      block_ends = 0;
      csr_writes = 0;
      burst_left = 0;
      sender_gaps = 1'b0;
      stall_mode = 0;
      hold_left = 0;
      idle_cycles = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_defaults();
      test_ceiling_extremes();
      test_release_extremes();
      test_block_end();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (40) @(posedge clock);
      $display("Checked %0d words over %0d register writes: %0d gain drops, %0d block ends.",
               words_checked, csr_writes, gain_drops, block_ends);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", errors);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
